[rtl/jsfe_pkg.sv]
package jsfe_pkg;

	localparam int KEY_MAX   = 16;
	localparam int WIN_DEPTH = KEY_MAX + 2;
	localparam int BYTE_W    = 8;
	localparam int LEN_W     = $clog2(KEY_MAX + 1);
	localparam int POS_W     = $clog2(WIN_DEPTH);
	localparam int IDX_W     = $clog2(KEY_MAX);
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LO  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HI  = 2'd2;

	typedef logic [KEY_MAX*BYTE_W-1:0] key_vec_t;

	typedef enum logic [1:0] {
		ST_FOUND   = 2'd0,
		ST_NOKEY   = 2'd1,
		ST_NOCOLON = 2'd2,
		ST_NOTSTR  = 2'd3
	} status_t;

	typedef enum logic [5:0] {
		PH_SEARCH = 6'b000001,
		PH_COLON  = 6'b000010,
		PH_SPACE  = 6'b000100,
		PH_VALUE  = 6'b001000,
		PH_ESCAPE = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	// one window slot as handed along the cell row
	typedef struct packed {
		logic              vld;
		logic [BYTE_W-1:0] data;
	} cell_data_t;

endpackage

[rtl/jsfe_cell.sv]
module jsfe_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    shift,
	input  logic                    clear,
	input  logic [jsfe_pkg::POS_W-1:0] pos,
	input  jsfe_pkg::key_vec_t      key,
	input  logic [jsfe_pkg::LEN_W-1:0] key_len,
	input  jsfe_pkg::cell_data_t    prev,
	output jsfe_pkg::cell_data_t    cur,
	output logic                    hit
);
	import jsfe_pkg::*;

	logic              vld_q;
	logic [BYTE_W-1:0] data_q;
	logic [LEN_W:0]    needle_len;
	logic [IDX_W-1:0]  key_idx;
	logic [LEN_W-1:0]  idx_full;
	logic [BYTE_W-1:0] want;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (clear) begin
			vld_q <= 1'b0;
		end else if (shift) begin
			vld_q <= prev.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= prev.data;
		end
	end

	// slot 0 and slot key_len+1 hold the quotes; slot p holds key byte key_len-p
	always_comb begin
		needle_len = {1'b0, key_len} + (LEN_W+1)'(2);
		idx_full   = key_len - LEN_W'(pos);
		key_idx    = idx_full[IDX_W-1:0];
		if (pos == '0 || {1'b0, LEN_W'(pos)} == needle_len - (LEN_W+1)'(1)) begin
			want = CH_QUOTE;
		end else begin
			want = key[key_idx*BYTE_W +: BYTE_W];
		end
		if ({1'b0, LEN_W'(pos)} >= needle_len) begin
			hit = 1'b1;
		end else begin
			hit = prev.vld && (prev.data == want);
		end
	end

	assign cur.vld  = vld_q;
	assign cur.data = data_q;

endmodule

[rtl/jsfe_window.sv]
module jsfe_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       shift,
	input  logic                       clear,
	input  logic [7:0]                 in_byte,
	input  jsfe_pkg::key_vec_t         key,
	input  logic [jsfe_pkg::LEN_W-1:0] key_len,
	output logic                       match
);
	import jsfe_pkg::*;

	cell_data_t             link [WIN_DEPTH+1];
	logic [WIN_DEPTH-1:0]   hits;

	assign link[0].vld  = 1'b1;
	assign link[0].data = in_byte;

	for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
		jsfe_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (shift),
			.clear   (clear),
			.pos     (POS_W'(i)),
			.key     (key),
			.key_len (key_len),
			.prev    (link[i]),
			.cur     (link[i+1]),
			.hit     (hits[i])
		);
	end

	// the last cell's output has no consumer beyond the row
	logic unused_tail;
	assign unused_tail = link[WIN_DEPTH].vld ^ (^link[WIN_DEPTH].data);

	// compare runs on the window as it stands after this byte shifts in
	assign match = &hits;

endmodule

[rtl/json_string_field_extractor.sv]
// Streaming extractor of a string value from a JSON body.
// Input channel: one body byte per transaction (in_byte, body_end marks the
// last byte of a body), handshake in_valid / in_stall.
// Output channel: at most one result per input transaction (value_byte,
// byte_valid, value_end, status), handshake out_valid / out_stall.
// Configuration: cfg_write with cfg_index 0 (key length), 1 (key bytes 0..7),
// 2 (key bytes 8..15); write only while idle.
// Output is registered: a result shows in the cycle after its byte is taken.
// Throughput: one byte per cycle while in_stall is low; the key compare
// runs in the row of window cells in the same cycle the byte enters the row.
// Reset clears the window, the phase and the key registers. After a body_end
// byte the block searches for the key again in the next body.
// When the output is stalled while holding a result, in_stall rises and the
// held result stays unchanged until taken.
module json_string_field_extractor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [jsfe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [jsfe_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     in_byte,
	input  logic                           body_end,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     value_byte,
	output logic                           byte_valid,
	output logic                           value_end,
	output logic [1:0]                     status
);
	import jsfe_pkg::*;

	logic [LEN_W-1:0] key_len_q;
	logic [CFG_W-1:0] key_lo_q;
	logic [CFG_W-1:0] key_hi_q;
	logic [LEN_W-1:0] eff_len;
	key_vec_t         key;

	phase_t phase_q, phase_nxt;
	logic   accept, match, is_space;

	logic              emit;
	logic [BYTE_W-1:0] r_byte;
	logic              r_bvalid, r_end;
	status_t           r_status;

	logic              out_valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              bvalid_q, end_q;
	status_t           status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q <= '0;
			key_lo_q  <= '0;
			key_hi_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_KEY_LEN: key_len_q <= cfg_data[LEN_W-1:0];
				CFG_KEY_LO:  key_lo_q  <= cfg_data;
				CFG_KEY_HI:  key_hi_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign eff_len = (key_len_q > LEN_W'(KEY_MAX)) ? LEN_W'(KEY_MAX) : key_len_q;
	assign key     = key_vec_t'({key_hi_q, key_lo_q});

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	jsfe_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (accept && phase_q == PH_SEARCH),
		.clear   (accept && body_end),
		.in_byte (in_byte),
		.key     (key),
		.key_len (eff_len),
		.match   (match)
	);

	assign is_space = (in_byte == CH_SPACE) || (in_byte >= CH_TAB && in_byte <= CH_CR);

	always_comb begin
		phase_nxt = phase_q;
		emit      = 1'b0;
		r_byte    = '0;
		r_bvalid  = 1'b0;
		r_end     = 1'b1;
		r_status  = ST_FOUND;
		unique case (phase_q)
			PH_SEARCH: begin
				if (match) begin
					phase_nxt = PH_COLON;
					emit      = body_end;
					r_status  = ST_NOCOLON;
				end else begin
					emit     = body_end;
					r_status = ST_NOKEY;
				end
			end
			PH_COLON: begin
				if (in_byte == CH_COLON) begin
					phase_nxt = PH_SPACE;
					emit      = body_end;
					r_status  = ST_NOTSTR;
				end else begin
					emit     = body_end;
					r_status = ST_NOCOLON;
				end
			end
			PH_SPACE: begin
				if (is_space) begin
					emit     = body_end;
					r_status = ST_NOTSTR;
				end else if (in_byte == CH_QUOTE) begin
					phase_nxt = PH_VALUE;
					emit      = body_end;
				end else begin
					phase_nxt = PH_DONE;
					emit      = 1'b1;
					r_status  = ST_NOTSTR;
				end
			end
			PH_VALUE: begin
				if (in_byte == CH_BSLASH) begin
					phase_nxt = PH_ESCAPE;
					emit      = body_end;
				end else if (in_byte == CH_QUOTE) begin
					phase_nxt = PH_DONE;
					emit      = 1'b1;
				end else begin
					emit     = 1'b1;
					r_byte   = in_byte;
					r_bvalid = 1'b1;
					r_end    = body_end;
				end
			end
			PH_ESCAPE: begin
				phase_nxt = PH_VALUE;
				emit      = 1'b1;
				r_byte    = in_byte;
				r_bvalid  = 1'b1;
				r_end     = body_end;
			end
			PH_DONE: ;
			default: ;
		endcase
		if (body_end) begin
			phase_nxt = PH_SEARCH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
		end else if (accept) begin
			phase_q <= phase_nxt;
		end
	end

	// output register; refilled in the same cycle the held transaction leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			byte_q   <= r_byte;
			bvalid_q <= r_bvalid;
			end_q    <= r_end;
			status_q <= r_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign value_byte = byte_q;
	assign byte_valid = bvalid_q;
	assign value_end  = end_q;
	assign status     = status_q;

endmodule

[rtl/jsfe_checker.sv]
module jsfe_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_write,
	input logic [jsfe_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [jsfe_pkg::CFG_W-1:0]     cfg_data,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic [7:0]                     in_byte,
	input logic                           body_end,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [7:0]                     value_byte,
	input logic                           byte_valid,
	input logic                           value_end,
	input logic [1:0]                     status
);
	import jsfe_pkg::*;

	logic unused_in;
	assign unused_in = cfg_write ^ (^cfg_index) ^ (^cfg_data) ^ in_valid ^ (^in_byte) ^ body_end;

	// a result without a value byte always closes the extraction
	a_nobyte_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> value_end)
		else $error("result without byte is not final");

	// failure codes only come on a closing result without a byte
	a_fail_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_FOUND |-> !byte_valid && value_end)
		else $error("failure status on byte or non-final result");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> value_byte == '0)
		else $error("value_byte nonzero without byte_valid");

	// input side only backs up behind a held output transaction
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free output");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value_byte) && $stable(status)
			&& $stable(byte_valid) && $stable(value_end))
		else $error("stalled output transaction changed");

endmodule

bind json_string_field_extractor jsfe_checker u_jsfe_checker (.*);
